// File: hdl/qft_pkg.sv
// Shared types and constants for the quoted field tokenizer.
package qft_pkg;

   typedef enum logic [2:0] {
      MODE_START    = 3'd0,
      MODE_UNQUOTED = 3'd1,
      MODE_QUOTED   = 3'd2,
      MODE_ESCAPE   = 3'd3,
      MODE_AFTERQ   = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      KIND_BYTE      = 3'd0,
      KIND_END       = 3'd1,
      KIND_LAST      = 3'd2,
      KIND_NOQUOTE   = 3'd3,
      KIND_BADESCAPE = 3'd4
   } kind_type;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_NL    = 8'h0A;

   typedef struct packed {
      logic       emit;
      kind_type   kind;
      logic [7:0] field_byte;
      logic       line_end;
   } result_type;

endpackage

// File: hdl/qft_req_if.sv
// Input channel interface: one line byte per transaction.
interface qft_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_byte;

   modport source (output valid, output line_byte, input ready);
   modport sink   (input valid, input line_byte, output ready);
endinterface

// File: hdl/qft_rsp_if.sv
// Result channel interface: one token per transaction.
interface qft_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] field_byte;
   logic       line_end;

   modport source (output valid, output kind, output field_byte, output line_end, input ready);
   modport sink   (input valid, input kind, input field_byte, input line_end, output ready);
endinterface

// File: hdl/qft_lexer.sv
// Lexer mode register and the per-byte token decode.
module qft_lexer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            line_byte,
   output qft_pkg::result_type   result
);

   qft_pkg::mode_type mode_ff;
   qft_pkg::mode_type mode_in;
   qft_pkg::kind_type kind;
   logic              emit;
   logic              is_nl;
   logic              is_blank;

   assign is_nl    = (line_byte == qft_pkg::CH_NL);
   assign is_blank = (line_byte == qft_pkg::CH_SPACE) || (line_byte == qft_pkg::CH_TAB);

   always_comb begin
      mode_in = mode_ff;
      emit    = 1'b1;
      kind    = qft_pkg::KIND_BYTE;
      unique case (mode_ff)
         qft_pkg::MODE_UNQUOTED: begin
            if (is_nl) begin
               mode_in = qft_pkg::MODE_START;
               kind    = qft_pkg::KIND_LAST;
            end else if (is_blank) begin
               mode_in = qft_pkg::MODE_START;
               kind    = qft_pkg::KIND_END;
            end
         end
         qft_pkg::MODE_QUOTED: begin
            if (is_nl) begin
               mode_in = qft_pkg::MODE_START;
               kind    = qft_pkg::KIND_NOQUOTE;
            end else if (line_byte == qft_pkg::CH_BSL) begin
               mode_in = qft_pkg::MODE_ESCAPE;
               emit    = 1'b0;
            end else if (line_byte == qft_pkg::CH_QUOTE) begin
               mode_in = qft_pkg::MODE_AFTERQ;
               emit    = 1'b0;
            end
         end
         qft_pkg::MODE_ESCAPE: begin
            if (is_nl) begin
               mode_in = qft_pkg::MODE_START;
               kind    = qft_pkg::KIND_BADESCAPE;
            end else begin
               mode_in = qft_pkg::MODE_QUOTED;
            end
         end
         qft_pkg::MODE_AFTERQ: begin
            // The byte after a closing quote is the separator and is dropped.
            mode_in = qft_pkg::MODE_START;
            kind    = is_nl ? qft_pkg::KIND_LAST : qft_pkg::KIND_END;
         end
         default: begin
            if (is_nl) begin
               mode_in = qft_pkg::MODE_START;
               kind    = qft_pkg::KIND_LAST;
            end else if (line_byte == qft_pkg::CH_QUOTE) begin
               mode_in = qft_pkg::MODE_QUOTED;
               emit    = 1'b0;
            end else if (is_blank) begin
               mode_in = qft_pkg::MODE_START;
               kind    = qft_pkg::KIND_END;
            end else begin
               mode_in = qft_pkg::MODE_UNQUOTED;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= qft_pkg::MODE_START;
      end else if (step) begin
         mode_ff <= mode_in;
      end
   end

   always_comb begin
      result.emit       = emit;
      result.kind       = kind;
      result.field_byte = (kind == qft_pkg::KIND_BYTE) ? line_byte : 8'h00;
      result.line_end   = (kind == qft_pkg::KIND_LAST) || (kind == qft_pkg::KIND_NOQUOTE) ||
                          (kind == qft_pkg::KIND_BADESCAPE);
   end

endmodule

// File: hdl/quoted_field_tokenizer_unit.sv
// Top level of the quoted field tokenizer: input register, lexer, result register.
//
// Usage: bytes of a command line arrive on req_chan, one per transaction; the
// byte 0x0A ends the line. Each byte gives at most one token on rsp_chan:
// kind 0 carries a field content byte in field_byte, kind 1 marks a field end,
// kind 2 the last field end of the line, kind 3 a missing closing quote and
// kind 4 a newline right after a backslash. line_end is set on the token that
// closes the line. Opening quotes, closing quotes and escape backslashes give
// no token. After an error the next byte starts a new line.
// Path: an accepted byte sits in the input register, is decoded, and its token is
// held in the result register, which drives rsp_chan.
// Throughput: one byte per cycle while rsp_chan is ready; the only state carried from
// byte to byte is the 3-bit lexer mode, updated in the same cycle the byte is decoded.
// Stalls: when rsp_chan is not ready, the token holds in the result register
// and one more byte waits in the input register; req_chan.ready then drops.
// Reset clears the lexer mode to field start and empties both registers.
module quoted_field_tokenizer_unit (
   input  logic         clock,
   input  logic         reset,
   qft_req_if.sink      req_chan,
   qft_rsp_if.source    rsp_chan
);

   logic                s1_valid_ff;
   logic [7:0]          s1_byte_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [2:0]          rsp_kind_ff;
   logic [7:0]          rsp_byte_ff;
   logic                rsp_line_end_ff;
   logic                advance;
   logic                fire;
   qft_pkg::result_type result;

   // The decode stage moves forward whenever the result register is free or being emptied.
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = s1_valid_ff && advance;
   assign req_chan.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         s1_byte_ff <= req_chan.line_byte;
      end
   end

   qft_lexer u_lexer (
      .clock     (clock),
      .reset     (reset),
      .step      (fire),
      .line_byte (s1_byte_ff),
      .result    (result)
   );

   assign rsp_valid_in = advance ? (fire && result.emit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && result.emit) begin
         rsp_kind_ff     <= result.kind;
         rsp_byte_ff     <= result.field_byte;
         rsp_line_end_ff <= result.line_end;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kind       = rsp_kind_ff;
   assign rsp_chan.field_byte = rsp_byte_ff;
   assign rsp_chan.line_end   = rsp_line_end_ff;

endmodule

// File: hdl/qft_checker.sv
// Port-level checker for the quoted field tokenizer, bound to the top level.
module qft_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_kind,
   input logic [7:0] rsp_field_byte,
   input logic       rsp_line_end
);

   // A stalled transaction keeps its token.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_field_byte) && $stable(rsp_line_end))
      else $error("result token changed while stalled");

   a_line_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_line_end == ((rsp_kind == qft_pkg::KIND_LAST) ||
                                      (rsp_kind == qft_pkg::KIND_NOQUOTE) ||
                                      (rsp_kind == qft_pkg::KIND_BADESCAPE))))
      else $error("line_end disagrees with kind");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != qft_pkg::KIND_BYTE) |-> (rsp_field_byte == 8'h00))
      else $error("field_byte not zero on a marker token");

   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind quoted_field_tokenizer_unit qft_checker u_qft_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_kind       (rsp_chan.kind),
   .rsp_field_byte (rsp_chan.field_byte),
   .rsp_line_end   (rsp_chan.line_end)
);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the quoted field tokenizer: directed and random line traffic with token prediction.
`timescale 1ns / 1ps

module tb_top;

   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_BYTES = 1100;

   typedef struct {
      qft_pkg::kind_type kind;
      logic [7:0]        field_byte;
      logic              line_end;
   } token_type;

   typedef struct {
      logic [7:0] line_byte;
      bit         drain_first;
   } line_item_type;

   logic clock;
   logic reset;

   qft_req_if req_chan ();
   qft_rsp_if rsp_chan ();

   quoted_field_tokenizer_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   line_item_type     pending_bytes[$];
   token_type         expected_tokens[$];
   qft_pkg::mode_type lex_mode;
   bit                drain_next;
   bit                req_taken;
   bit                send_quiet;
   bit                recv_quiet;
   int                send_gap;
   int                recv_stall;
   int                idle_cycles;
   int                error_count;
   int                bytes_accepted;
   int                total_bytes;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic void add_token(qft_pkg::kind_type k, logic [7:0] b);
      token_type t;
      t.kind       = k;
      t.field_byte = (k == qft_pkg::KIND_BYTE) ? b : 8'h00;
      t.line_end   = (k == qft_pkg::KIND_LAST) || (k == qft_pkg::KIND_NOQUOTE) ||
                     (k == qft_pkg::KIND_BADESCAPE);
      expected_tokens.insert(expected_tokens.size(), t);
   endfunction

   // Advances the lexer mode by one byte and queues the token it produces, if any.
   function automatic void tokenize_byte(logic [7:0] b);
      logic blank;
      blank = (b == qft_pkg::CH_SPACE) || (b == qft_pkg::CH_TAB);
      unique case (lex_mode)
         qft_pkg::MODE_UNQUOTED: begin
            if (b == qft_pkg::CH_NL) begin
               lex_mode = qft_pkg::MODE_START;
               add_token(qft_pkg::KIND_LAST, 8'h00);
            end else if (blank) begin
               lex_mode = qft_pkg::MODE_START;
               add_token(qft_pkg::KIND_END, 8'h00);
            end else begin
               add_token(qft_pkg::KIND_BYTE, b);
            end
         end
         qft_pkg::MODE_QUOTED: begin
            if (b == qft_pkg::CH_NL) begin
               lex_mode = qft_pkg::MODE_START;
               add_token(qft_pkg::KIND_NOQUOTE, 8'h00);
            end else if (b == qft_pkg::CH_BSL) begin
               lex_mode = qft_pkg::MODE_ESCAPE;
            end else if (b == qft_pkg::CH_QUOTE) begin
               lex_mode = qft_pkg::MODE_AFTERQ;
            end else begin
               add_token(qft_pkg::KIND_BYTE, b);
            end
         end
         qft_pkg::MODE_ESCAPE: begin
            if (b == qft_pkg::CH_NL) begin
               lex_mode = qft_pkg::MODE_START;
               add_token(qft_pkg::KIND_BADESCAPE, 8'h00);
            end else begin
               lex_mode = qft_pkg::MODE_QUOTED;
               add_token(qft_pkg::KIND_BYTE, b);
            end
         end
         qft_pkg::MODE_AFTERQ: begin
            // Whatever follows the closing quote is taken as the separator.
            lex_mode = qft_pkg::MODE_START;
            add_token((b == qft_pkg::CH_NL) ? qft_pkg::KIND_LAST : qft_pkg::KIND_END, 8'h00);
         end
         default: begin
            if (b == qft_pkg::CH_NL) begin
               lex_mode = qft_pkg::MODE_START;
               add_token(qft_pkg::KIND_LAST, 8'h00);
            end else if (b == qft_pkg::CH_QUOTE) begin
               lex_mode = qft_pkg::MODE_QUOTED;
            end else if (blank) begin
               lex_mode = qft_pkg::MODE_START;
               add_token(qft_pkg::KIND_END, 8'h00);
            end else begin
               lex_mode = qft_pkg::MODE_UNQUOTED;
               add_token(qft_pkg::KIND_BYTE, b);
            end
         end
      endcase
   endfunction

   function automatic void queue_byte(logic [7:0] b);
      line_item_type item;
      item.line_byte   = b;
      item.drain_first = drain_next;
      drain_next       = 1'b0;
      pending_bytes.insert(pending_bytes.size(), item);
   endfunction

   // Random byte with a heavy share of the bytes the lexer treats specially.
   function automatic logic [7:0] noisy_byte();
      if ($urandom_range(0, 99) < 30) begin
         case ($urandom_range(0, 4))
            0: return qft_pkg::CH_SPACE;
            1: return qft_pkg::CH_TAB;
            2: return qft_pkg::CH_QUOTE;
            3: return qft_pkg::CH_BSL;
            default: return qft_pkg::CH_NL;
         endcase
      end
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] plain_byte(bit no_quote);
      logic [7:0] b;
      do begin
         b = noisy_byte();
      end while (b == qft_pkg::CH_SPACE || b == qft_pkg::CH_TAB || b == qft_pkg::CH_NL ||
                 (no_quote && b == qft_pkg::CH_QUOTE));
      return b;
   endfunction

   function automatic logic [7:0] blank_byte();
      return $urandom_range(0, 1) ? qft_pkg::CH_SPACE : qft_pkg::CH_TAB;
   endfunction

   // Quoted content: specials and a few ordinary bytes go behind a backslash.
   function automatic void queue_quoted_body(int n);
      logic [7:0] b;
      repeat (n) begin
         b = noisy_byte();
         if (b == qft_pkg::CH_QUOTE || b == qft_pkg::CH_BSL || b == qft_pkg::CH_NL ||
             $urandom_range(0, 9) == 0)
            queue_byte(qft_pkg::CH_BSL);
         queue_byte(b);
      end
   endfunction

   function automatic void queue_random_line();
      int  style;
      int  fields;
      bit  prev_quoted;
      style = $urandom_range(0, 99);
      if (style < 10) begin
         repeat ($urandom_range(1, 20)) queue_byte(noisy_byte());
         queue_byte(qft_pkg::CH_NL);
         return;
      end
      fields = $urandom_range(0, 5);
      prev_quoted = 1'b0;
      for (int i = 0; i < fields; i++) begin
         if (i > 0) begin
            if (prev_quoted)
               queue_byte(($urandom_range(0, 3) == 0) ? plain_byte(1'b0) : blank_byte());
            else
               repeat ($urandom_range(1, 2)) queue_byte(blank_byte());
         end
         prev_quoted = ($urandom_range(0, 99) < 40);
         if (prev_quoted) begin
            queue_byte(qft_pkg::CH_QUOTE);
            queue_quoted_body($urandom_range(0, 8));
            queue_byte(qft_pkg::CH_QUOTE);
         end else begin
            queue_byte(plain_byte(1'b1));
            repeat ($urandom_range(0, 7)) queue_byte(plain_byte(1'b0));
         end
      end
      if (style < 22) begin
         // A quoted field cut off by the newline, bare or right after a backslash.
         if (fields > 0)
            queue_byte(prev_quoted ? plain_byte(1'b0) : blank_byte());
         queue_byte(qft_pkg::CH_QUOTE);
         queue_quoted_body($urandom_range(0, 5));
         if ($urandom_range(0, 1))
            queue_byte(qft_pkg::CH_BSL);
         queue_byte(qft_pkg::CH_NL);
         return;
      end
      if ($urandom_range(0, 9) == 0)
         queue_byte(blank_byte());
      queue_byte(qft_pkg::CH_NL);
   endfunction

   // Stall lengths: mostly none or short, now and then long.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Input driver: presents the next pending byte once the previous transaction is done.
   always @(negedge clock) begin : drive_req
      logic          next_valid;
      logic [7:0]    next_byte;
      line_item_type item;
      next_valid = req_chan.valid;
      next_byte  = req_chan.line_byte;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         next_valid = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_bytes.size() > 0 &&
                      !(pending_bytes[0].drain_first && expected_tokens.size() > 0)) begin
            item       = pending_bytes.pop_front();
            next_valid = 1'b1;
            next_byte  = item.line_byte;
            if ($urandom_range(0, 49) == 0)
               send_quiet = !send_quiet;
            send_gap = send_quiet ? 0 : idle_length();
         end
      end
      req_chan.valid     <= next_valid;
      req_chan.line_byte <= next_byte;
   end

   // Result side back-pressure.
   always @(negedge clock) begin : drive_rsp
      logic next_ready;
      if (reset) begin
         next_ready = 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         next_ready = 1'b0;
      end else begin
         next_ready = 1'b1;
         if ($urandom_range(0, 49) == 0)
            recv_quiet = !recv_quiet;
         recv_stall = recv_quiet ? 0 : idle_length();
      end
      rsp_chan.ready <= next_ready;
   end

   // Monitor: predicts on accepted bytes, checks accepted tokens, and guards against hangs.
   always @(posedge clock) begin : monitor
      token_type want;
      bit        rsp_taken;
      if (reset) begin
         lex_mode    = qft_pkg::MODE_START;
         req_taken   = 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken = req_chan.valid && req_chan.ready;
         rsp_taken = rsp_chan.valid && rsp_chan.ready;
         if (req_taken) begin
            tokenize_byte(req_chan.line_byte);
            bytes_accepted++;
         end
         if (rsp_taken) begin
            if (expected_tokens.size() == 0) begin
               report_mismatch($sformatf("unexpected token: kind %0d byte %02h line_end %0b",
                                         rsp_chan.kind, rsp_chan.field_byte, rsp_chan.line_end));
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_chan.kind !== want.kind)
                  report_mismatch($sformatf("kind %0d, expected %0d", rsp_chan.kind, want.kind));
               if (rsp_chan.field_byte !== want.field_byte)
                  report_mismatch($sformatf("field_byte %02h, expected %02h",
                                            rsp_chan.field_byte, want.field_byte));
               if (rsp_chan.line_end !== want.line_end)
                  report_mismatch($sformatf("line_end %0b, expected %0b",
                                            rsp_chan.line_end, want.line_end));
            end
         end
         if (req_taken || rsp_taken)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("ERROR @%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [7:0] directed[24];
      directed = '{
         qft_pkg::CH_NL,                                     // empty line
         qft_pkg::CH_SPACE, qft_pkg::CH_TAB, qft_pkg::CH_NL, // adjacent blanks
         8'hFF, qft_pkg::CH_QUOTE, 8'h00, qft_pkg::CH_NL,    // quote inside an unquoted field
         qft_pkg::CH_QUOTE, qft_pkg::CH_BSL, qft_pkg::CH_QUOTE, 8'h80, qft_pkg::CH_QUOTE,
         8'h7F, qft_pkg::CH_NL,
         qft_pkg::CH_QUOTE, qft_pkg::CH_QUOTE, qft_pkg::CH_NL, // newline after closing quote
         qft_pkg::CH_QUOTE, 8'h41, qft_pkg::CH_NL,           // missing closing quote
         qft_pkg::CH_QUOTE, qft_pkg::CH_BSL, qft_pkg::CH_NL  // newline after backslash
      };
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.line_byte = 8'h00;
      rsp_chan.ready     = 1'b0;
      lex_mode           = qft_pkg::MODE_START;
      drain_next         = 1'b0;
      req_taken          = 1'b0;
      send_quiet         = 1'b0;
      recv_quiet         = 1'b0;
      send_gap           = 0;
      recv_stall         = 0;
      idle_cycles        = 0;
      error_count        = 0;
      bytes_accepted     = 0;

      foreach (directed[i]) queue_byte(directed[i]);
      // The sender holds off until every directed token has been seen.
      drain_next = 1'b1;
      while (pending_bytes.size() < RANDOM_BYTES + 24) begin
         if ($urandom_range(0, 99) < 3)
            drain_next = 1'b1;
         queue_random_line();
      end
      total_bytes = pending_bytes.size();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (bytes_accepted < total_bytes || expected_tokens.size() > 0) @(negedge clock);
      repeat (8) @(negedge clock);

      if (error_count == 0 && expected_tokens.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/qft_pkg.sv
hdl/qft_req_if.sv
hdl/qft_rsp_if.sv
hdl/qft_lexer.sv
hdl/quoted_field_tokenizer_unit.sv
hdl/qft_checker.sv
tb/sv/tb_top.sv
